/* hw/rtl/tcpsq_pkg.sv */
// Package: request and result types and defaults for the TCP sequence/ack rewriter.
package tcpsq_pkg;

	localparam int FLOW_ENTRIES_DEF = 16;

	typedef enum logic [1:0] {
		KIND_INSTALL = 2'd0,
		KIND_INGRESS = 2'd1,
		KIND_EGRESS  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        short_frame;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] seq_number;
		logic [31:0] ack_number;
	} req_t;

	typedef struct packed {
		logic [31:0] out_seq;
		logic [31:0] out_ack;
		logic        matched;
		logic        rewritten;
		logic        event_valid;
		logic [31:0] event_seq_offset;
		logic [31:0] event_ack_offset;
		logic        install_ok;
	} rsp_t;

endpackage

/* hw/rtl/tcp_seq_ack_flow_rewriter.sv */
// Top level: per-flow TCP sequence/ack number translator with a flow table in flip-flops.
//
// Takes one request per clock unless stalled and returns one result per request, in order,
// through two registers (request register, then result register). The flow table lives in
// flip-flops: every entry's key (address, port) is compared in parallel against the
// request key, so lookup, learning and install all finish combinationally between the
// two registers, and an entry written by one request is seen by the very next one.
// Install requests (kind 0) store or overwrite an entry keyed by source IP and port;
// they report install_ok 0 when the key is new and the table is full. Ingress packets
// (kind 1) look up by source IP/port: the first hit learns seq/ack offsets as wanted
// start minus packet value (mod 2^32), and every hit adds them. Egress packets (kind 2)
// look up by destination IP/port and subtract the offsets crosswise (seq - ack offset,
// ack - seq offset) once learned; before that they pass unchanged but still report the
// event. Short ingress and egress frames, misses and kind 3 pass through untouched with all flags clear.
// The request side stalls only while a result is held and the result side stalls.
// No clearing pass after reset: of the table, only the valid and learned bits are reset.
module tcp_seq_ack_flow_rewriter #(
	parameter int FLOW_ENTRIES = tcpsq_pkg::FLOW_ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  tcpsq_pkg::req_t  req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output tcpsq_pkg::rsp_t  rsp
);

	localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

	// request register
	logic            req_valid_s1;
	tcpsq_pkg::req_t req_s1;

	// result register
	logic            rsp_valid_q;
	tcpsq_pkg::rsp_t rsp_q;

	// flow table
	logic [FLOW_ENTRIES-1:0] valid_q;
	logic [FLOW_ENTRIES-1:0] learned_q;
	logic [31:0] key_addr_q  [FLOW_ENTRIES];
	logic [15:0] key_port_q  [FLOW_ENTRIES];
	logic [31:0] seq_start_q [FLOW_ENTRIES];
	logic [31:0] ack_start_q [FLOW_ENTRIES];
	logic [31:0] seq_off_q   [FLOW_ENTRIES];
	logic [31:0] ack_off_q   [FLOW_ENTRIES];

	logic                    rsp_move;
	logic                    fire;
	logic [31:0]             lkp_addr;
	logic [15:0]             lkp_port;
	logic [FLOW_ENTRIES-1:0] hit_vec;
	logic [FLOW_ENTRIES-1:0] free_vec;
	logic                    hit;
	logic                    any_free;
	logic [IDX_W-1:0]        hit_idx;
	logic [IDX_W-1:0]        free_idx;
	logic [IDX_W-1:0]        wr_idx;
	logic                    hit_learned;
	logic [31:0]             hit_seq_start;
	logic [31:0]             hit_ack_start;
	logic [31:0]             hit_seq_off;
	logic [31:0]             hit_ack_off;
	logic [31:0]             cur_seq_off;
	logic [31:0]             cur_ack_off;
	logic                    do_install;
	logic                    do_learn;
	tcpsq_pkg::rsp_t         rsp_next;

	// handshake: result register advances when empty or taken
	assign rsp_move  = !rsp_valid_q || !rsp_stall;
	assign req_stall = req_valid_s1 && !rsp_move;
	assign fire      = req_valid_s1 && rsp_move;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// lookup key: egress uses the destination side
	assign lkp_addr = (req_s1.kind == tcpsq_pkg::KIND_EGRESS) ? req_s1.dst_ip : req_s1.src_ip;
	assign lkp_port = (req_s1.kind == tcpsq_pkg::KIND_EGRESS) ? req_s1.dst_port : req_s1.src_port;

	always_comb begin
		hit_idx       = '0;
		free_idx      = '0;
		hit_learned   = 1'b0;
		hit_seq_start = '0;
		hit_ack_start = '0;
		hit_seq_off   = '0;
		hit_ack_off   = '0;
		for (int i = 0; i < FLOW_ENTRIES; i++) begin
			hit_vec[i]  = valid_q[i] && (key_addr_q[i] == lkp_addr) &&
				(key_port_q[i] == lkp_port);
			free_vec[i] = !valid_q[i];
		end
		// keys are unique, so at most one hit: OR the hit entry's fields together
		for (int i = 0; i < FLOW_ENTRIES; i++) begin
			if (hit_vec[i]) begin
				hit_idx       = hit_idx | IDX_W'(i);
				hit_learned   = hit_learned | learned_q[i];
				hit_seq_start = hit_seq_start | seq_start_q[i];
				hit_ack_start = hit_ack_start | ack_start_q[i];
				hit_seq_off   = hit_seq_off | seq_off_q[i];
				hit_ack_off   = hit_ack_off | ack_off_q[i];
			end
		end
		// lowest free entry
		for (int i = FLOW_ENTRIES - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign hit      = |hit_vec;
	assign any_free = |free_vec;
	assign wr_idx   = hit ? hit_idx : free_idx;

	// ingress learns the offsets on its first hit
	assign cur_seq_off = hit_learned ? hit_seq_off : (hit_seq_start - req_s1.seq_number);
	assign cur_ack_off = hit_learned ? hit_ack_off : (hit_ack_start - req_s1.ack_number);

	always_comb begin
		do_install = 1'b0;
		do_learn   = 1'b0;
		rsp_next                  = '0;
		rsp_next.out_seq          = req_s1.seq_number;
		rsp_next.out_ack          = req_s1.ack_number;
		case (req_s1.kind)
			tcpsq_pkg::KIND_INSTALL: begin
				do_install          = hit || any_free;
				rsp_next.install_ok = hit || any_free;
			end
			tcpsq_pkg::KIND_INGRESS: begin
				if (!req_s1.short_frame && hit) begin
					do_learn                  = !hit_learned;
					rsp_next.matched          = 1'b1;
					rsp_next.event_valid      = 1'b1;
					rsp_next.rewritten        = 1'b1;
					rsp_next.event_seq_offset = cur_seq_off;
					rsp_next.event_ack_offset = cur_ack_off;
					rsp_next.out_seq          = req_s1.seq_number + cur_seq_off;
					rsp_next.out_ack          = req_s1.ack_number + cur_ack_off;
				end
			end
			tcpsq_pkg::KIND_EGRESS: begin
				if (!req_s1.short_frame && hit) begin
					rsp_next.matched          = 1'b1;
					rsp_next.event_valid      = 1'b1;
					rsp_next.event_seq_offset = hit_seq_off;
					rsp_next.event_ack_offset = hit_ack_off;
					if (hit_learned) begin
						rsp_next.rewritten = 1'b1;
						rsp_next.out_seq   = req_s1.seq_number - hit_ack_off;
						rsp_next.out_ack   = req_s1.ack_number - hit_seq_off;
					end
				end
			end
			default: begin
				// unknown kind: pass through
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_q  <= 1'b0;
			valid_q      <= '0;
			learned_q    <= '0;
		end else begin
			if (!req_stall) begin
				req_valid_s1 <= req_valid;
			end
			if (rsp_move) begin
				rsp_valid_q <= req_valid_s1;
			end
			if (fire && do_install) begin
				valid_q[wr_idx]   <= 1'b1;
				learned_q[wr_idx] <= 1'b0;
			end
			if (fire && do_learn) begin
				learned_q[hit_idx] <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (fire) begin
			rsp_q <= rsp_next;
		end
		if (fire && do_install) begin
			key_addr_q[wr_idx]  <= req_s1.src_ip;
			key_port_q[wr_idx]  <= req_s1.src_port;
			seq_start_q[wr_idx] <= req_s1.seq_number;
			ack_start_q[wr_idx] <= req_s1.ack_number;
			seq_off_q[wr_idx]   <= '0;
			ack_off_q[wr_idx]   <= '0;
		end
		if (fire && do_learn) begin
			seq_off_q[hit_idx] <= cur_seq_off;
			ack_off_q[hit_idx] <= cur_ack_off;
		end
	end

	// a key lives in at most one valid entry
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid_s1 |-> $onehot0(hit_vec))
		else $error("flow key matched more than one entry");

	// only valid entries can have learned offsets
	a_learned_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(learned_q & ~valid_q) == '0)
		else $error("learned bit set on an empty entry");

	// rewrite only follows a table hit
	a_rewrite_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.rewritten |-> rsp_q.matched && rsp_q.event_valid)
		else $error("rewritten without a matching entry");

	// install results never carry packet flags
	a_install_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.install_ok |-> !rsp_q.matched && !rsp_q.event_valid)
		else $error("install result carries packet flags");

	// a learning hit leaves the entry learned
	a_learn_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		fire && do_learn |=> learned_q[$past(hit_idx)])
		else $error("offsets not marked learned");

endmodule

/* bench/tcp_seq_ack_flow_rewriter_tb.sv */
// Testbench for the TCP seq/ack flow rewriter: directed and random requests, scoreboard check.
module tcp_seq_ack_flow_rewriter_tb;

	localparam int FLOWS = tcpsq_pkg::FLOW_ENTRIES_DEF;
	// kind 3 has no meaning in the block; it must pass through untouched
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 1820;
	localparam int STEADY_TAIL = 150;	// last requests run with no idling on either side
	localparam int LONG_HOLD = 64;		// result side holds off this long once
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_TAIL = 8;		// result passes the request and result registers after its request

	// Scoreboard: keeps its own copy of the flow table and predicts each result
	// at the moment its request is accepted. The block handles requests in order
	// and a table write is visible to the very next request, so predicting in
	// acceptance order matches the hardware.
	class flow_rewrite_scoreboard;
		bit              flow_used [FLOWS];
		bit              flow_learned [FLOWS];
		logic [31:0]     flow_addr [FLOWS];
		logic [15:0]     flow_port [FLOWS];
		logic [31:0]     start_seq [FLOWS];
		logic [31:0]     start_ack [FLOWS];
		logic [31:0]     seq_shift [FLOWS];
		logic [31:0]     ack_shift [FLOWS];
		tcpsq_pkg::rsp_t expected_rewrites [$];
		int              errors;

		function int find_flow(logic [31:0] addr, logic [15:0] port);
			for (int i = 0; i < FLOWS; i++)
				if (flow_used[i] && flow_addr[i] == addr && flow_port[i] == port)
					return i;
			return -1;
		endfunction

		function int find_free();
			for (int i = 0; i < FLOWS; i++)
				if (!flow_used[i])
					return i;
			return -1;
		endfunction

		function int pending();
			return expected_rewrites.size();
		endfunction

		function void take_request(tcpsq_pkg::req_t r);
			tcpsq_pkg::rsp_t e;
			int              slot;
			e = '0;
			e.out_seq = r.seq_number;
			e.out_ack = r.ack_number;
			case (r.kind)
				tcpsq_pkg::KIND_INSTALL: begin
					// overwrite in place on a known key, else lowest free entry
					slot = find_flow(r.src_ip, r.src_port);
					if (slot < 0)
						slot = find_free();
					if (slot >= 0) begin
						flow_used[slot] = 1'b1;
						flow_learned[slot] = 1'b0;
						flow_addr[slot] = r.src_ip;
						flow_port[slot] = r.src_port;
						start_seq[slot] = r.seq_number;
						start_ack[slot] = r.ack_number;
						seq_shift[slot] = '0;
						ack_shift[slot] = '0;
						e.install_ok = 1'b1;
					end
				end
				tcpsq_pkg::KIND_INGRESS: begin
					slot = r.short_frame ? -1 : find_flow(r.src_ip, r.src_port);
					if (slot >= 0) begin
						// first hit after install fixes the offsets
						if (!flow_learned[slot]) begin
							seq_shift[slot] = start_seq[slot] - r.seq_number;
							ack_shift[slot] = start_ack[slot] - r.ack_number;
							flow_learned[slot] = 1'b1;
						end
						e.matched = 1'b1;
						e.event_valid = 1'b1;
						e.rewritten = 1'b1;
						e.event_seq_offset = seq_shift[slot];
						e.event_ack_offset = ack_shift[slot];
						e.out_seq = r.seq_number + seq_shift[slot];
						e.out_ack = r.ack_number + ack_shift[slot];
					end
				end
				tcpsq_pkg::KIND_EGRESS: begin
					slot = r.short_frame ? -1 : find_flow(r.dst_ip, r.dst_port);
					if (slot >= 0) begin
						e.matched = 1'b1;
						e.event_valid = 1'b1;
						e.event_seq_offset = seq_shift[slot];
						e.event_ack_offset = ack_shift[slot];
						// crosswise subtraction, only once offsets are known
						if (flow_learned[slot]) begin
							e.out_seq = r.seq_number - ack_shift[slot];
							e.out_ack = r.ack_number - seq_shift[slot];
							e.rewritten = 1'b1;
						end
					end
				end
				default: ;
			endcase
			expected_rewrites.push_back(e);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %h, got %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_rewrite(tcpsq_pkg::rsp_t got);
			tcpsq_pkg::rsp_t want;
			if (expected_rewrites.size() == 0) begin
				$display("%0t: result expected none, got %h", $time, got);
				errors++;
				return;
			end
			want = expected_rewrites.pop_front();
			compare_field("out_seq", want.out_seq, got.out_seq);
			compare_field("out_ack", want.out_ack, got.out_ack);
			compare_field("matched", 32'(want.matched), 32'(got.matched));
			compare_field("rewritten", 32'(want.rewritten), 32'(got.rewritten));
			compare_field("event_valid", 32'(want.event_valid), 32'(got.event_valid));
			compare_field("event_seq_offset", want.event_seq_offset, got.event_seq_offset);
			compare_field("event_ack_offset", want.event_ack_offset, got.event_ack_offset);
			compare_field("install_ok", 32'(want.install_ok), 32'(got.install_ok));
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	tcpsq_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	tcpsq_pkg::rsp_t rsp;

	flow_rewrite_scoreboard flow_sb = new();

	// Flow keys used by the random part. Slot 0 and slot 1 carry the extreme
	// key values; the rest are random. All of them get installed up front, so
	// the table is full for the whole random part and new keys are refused.
	logic [31:0] pool_addr [FLOWS];
	logic [15:0] pool_port [FLOWS];

	// Idling controls, changed by the request process between segments
	int send_idle_pct = 20;
	int sink_idle_pct = 20;
	int burst_free_left = 0;	// requests still to be sent back to back
	bit steady_tail = 1'b0;
	bit sink_hold_pending = 1'b0;
	int idle_cycles = 0;

	tcp_seq_ack_flow_rewriter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Word picker: leans on 0 and all-ones so the mod 2^32 wrap gets exercised
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic int idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 45;
		endcase
	endfunction

	// Builds one request. slot >= 0 puts a pool key where the block looks for
	// it (source for install and ingress, destination for egress); slot -1
	// leaves a random key, which misses or hits a full table.
	function automatic tcpsq_pkg::req_t flow_request(logic [1:0] kind, int slot, logic sf,
			logic [31:0] seq, logic [31:0] ack);
		tcpsq_pkg::req_t r;
		r.kind = kind;
		r.short_frame = sf;
		r.src_ip = $urandom;
		r.dst_ip = $urandom;
		r.src_port = 16'($urandom_range(0, 16'hFFFF));
		r.dst_port = 16'($urandom_range(0, 16'hFFFF));
		r.seq_number = seq;
		r.ack_number = ack;
		if (slot >= 0 && kind == tcpsq_pkg::KIND_EGRESS) begin
			r.dst_ip = pool_addr[slot];
			r.dst_port = pool_port[slot];
		end else if (slot >= 0) begin
			r.src_ip = pool_addr[slot];
			r.src_port = pool_port[slot];
		end
		return r;
	endfunction

	// Mostly traffic on installed flows; re-installs restart offset learning.
	function automatic tcpsq_pkg::req_t random_request();
		int   roll;
		int   slot;
		logic sf;
		roll = $urandom_range(0, 99);
		slot = $urandom_range(0, FLOWS - 1);
		sf = ($urandom_range(0, 9) == 0);
		if (roll < 40)
			return flow_request(tcpsq_pkg::KIND_INGRESS, slot, sf, pick_word(), pick_word());
		if (roll < 64)
			return flow_request(tcpsq_pkg::KIND_EGRESS, slot, sf, pick_word(), pick_word());
		if (roll < 76)
			return flow_request(tcpsq_pkg::KIND_INSTALL, slot, sf, pick_word(), pick_word());
		if (roll < 81)
			return flow_request(tcpsq_pkg::KIND_INSTALL, -1, sf, pick_word(), pick_word());
		if (roll < 88)
			return flow_request(tcpsq_pkg::KIND_INGRESS, -1, sf, pick_word(), pick_word());
		if (roll < 95)
			return flow_request(tcpsq_pkg::KIND_EGRESS, -1, sf, pick_word(), pick_word());
		return flow_request(KIND_UNUSED, slot, sf, pick_word(), pick_word());
	endfunction

	function automatic int sender_gap();
		if (steady_tail || burst_free_left > 0 || $urandom_range(0, 99) >= send_idle_pct)
			return 0;
		return $urandom_range(1, 8);
	endfunction

	// Offers one request, holding it steady until taken. Called at a clock edge.
	task automatic send_request(input tcpsq_pkg::req_t r);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		flow_sb.take_request(r);
	endtask

	// Stop offering until every predicted result has come back
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (flow_sb.pending() != 0);
	endtask

	initial begin : request_source
		foreach (pool_addr[i]) begin
			pool_addr[i] = $urandom;
			pool_port[i] = 16'($urandom_range(0, 16'hFFFF));
		end
		pool_addr[0] = 32'hFFFF_FFFF;
		pool_port[0] = 16'hFFFF;
		pool_addr[1] = 32'h0;
		pool_port[1] = 16'h0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Empty table first: both directions miss, kind 3 ignored.
		send_request(flow_request(tcpsq_pkg::KIND_INGRESS, 0, 1'b0, 32'hFFFF_FFFF, 32'h0));
		send_request(flow_request(tcpsq_pkg::KIND_EGRESS, 0, 1'b0, 32'h0, 32'hFFFF_FFFF));
		send_request(flow_request(KIND_UNUSED, 0, 1'b0, 32'h1234_5678, 32'h9ABC_DEF0));
		// install with short_frame set, which install must ignore
		send_request(flow_request(tcpsq_pkg::KIND_INSTALL, 0, 1'b1, 32'hFFFF_FFFF, 32'h0));
		// egress before learning: matched and event, packet unchanged
		send_request(flow_request(tcpsq_pkg::KIND_EGRESS, 0, 1'b0, 32'h5, 32'h7));
		// first ingress learns offsets all-ones and one; the ack offset wraps
		send_request(flow_request(tcpsq_pkg::KIND_INGRESS, 0, 1'b0, 32'h0, 32'hFFFF_FFFF));
		send_request(flow_request(tcpsq_pkg::KIND_INGRESS, 0, 1'b0, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		send_request(flow_request(tcpsq_pkg::KIND_EGRESS, 0, 1'b0, 32'h0, 32'h0));
		// short frames on a live flow pass untouched
		send_request(flow_request(tcpsq_pkg::KIND_INGRESS, 0, 1'b1, 32'h0, 32'h0));
		send_request(flow_request(tcpsq_pkg::KIND_EGRESS, 0, 1'b1, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		// re-install on the same key overwrites and forgets the offsets
		send_request(flow_request(tcpsq_pkg::KIND_INSTALL, 0, 1'b0, 32'h0, 32'hFFFF_FFFF));
		send_request(flow_request(tcpsq_pkg::KIND_INGRESS, 0, 1'b0, $urandom, $urandom));
		// fill the table, then a new key is refused and a known key still lands
		for (int s = 1; s < FLOWS; s++)
			send_request(flow_request(tcpsq_pkg::KIND_INSTALL, s, 1'b0, pick_word(),
				pick_word()));
		send_request(flow_request(tcpsq_pkg::KIND_INSTALL, -1, 1'b0, pick_word(), pick_word()));
		send_request(flow_request(tcpsq_pkg::KIND_INSTALL, 5, 1'b0, pick_word(), pick_word()));

		// Random part, in segments with their own idling mix
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i % 240 == 0) begin
				send_idle_pct = idle_pct();
				sink_idle_pct = idle_pct();
			end
			if (i == 600) begin
				// result side holds off while requests keep coming back to back,
				// so the block fills and stalls its request side
				sink_hold_pending = 1'b1;
				burst_free_left = 40;
			end
			if (i == 1200)
				wait_for_drain();
			steady_tail = (i >= RANDOM_REQUESTS - STEADY_TAIL);
			send_request(random_request());
			if (burst_free_left > 0)
				burst_free_left--;
		end

		wait_for_drain();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (flow_sb.errors == 0)
			$display("tcp_seq_ack_flow_rewriter_tb: done, clean");
		else
			$display("tcp_seq_ack_flow_rewriter_tb: done, errors");
		$finish;
	end

	// Result side: random stall bursts, one long hold on request, none in the tail
	initial begin : result_sink
		int burst;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold_pending) begin
				sink_hold_pending = 1'b0;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (!steady_tail && $urandom_range(0, 99) < sink_idle_pct) begin
				burst = $urandom_range(1, 8);
				rsp_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			flow_sb.check_rewrite(rsp);
	end

	// Watchdog: too long with no request or result taken means the block hung
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tcp_seq_ack_flow_rewriter_tb: done, errors");
				$finish;
			end
		end
	end

endmodule
